@@ src/five_way_key_debounce_fsm_unit_defines.svh @@
// Assertion macros used by the joystick debouncer RTL (fwkd_fsm).
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef FIVE_WAY_KEY_DEBOUNCE_FSM_UNIT_DEFINES_SVH
`define FIVE_WAY_KEY_DEBOUNCE_FSM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FWKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fwkd_pkg.sv @@
`default_nettype none
package fwkd_pkg;

  localparam int unsigned PinW  = 5;
  localparam int unsigned CodeW = 3;
  localparam int unsigned SkipW = 8;

  localparam logic [SkipW-1:0] SCAN_SKIP_RESET = 8'd15;

  // item kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // key codes
  localparam logic [CodeW-1:0] KEY_NONE  = 3'd0;
  localparam logic [CodeW-1:0] KEY_UP    = 3'd1;
  localparam logic [CodeW-1:0] KEY_DOWN  = 3'd2;
  localparam logic [CodeW-1:0] KEY_LEFT  = 3'd3;
  localparam logic [CodeW-1:0] KEY_RIGHT = 3'd4;
  localparam logic [CodeW-1:0] KEY_ENTER = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_PRESSED    = 5'b00010,
    ST_PRESS_OK   = 5'b00100,
    ST_RELEASED   = 5'b01000,
    ST_RELEASE_OK = 5'b10000
  } fsm_state_t;

  // one item leaving the input register
  typedef struct packed {
    logic             fire;
    logic             is_read;
    logic [PinW-1:0]  pin_levels;
  } step_t;

  // key status as seen by a read
  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic             press_flag;
    logic             release_flag;
  } status_t;

endpackage
`default_nettype wire

@@ src/fwkd_prio_enc.sv @@
`default_nettype none
module fwkd_prio_enc (
  input  wire logic [fwkd_pkg::PinW-1:0]  pin_levels,
  output logic      [fwkd_pkg::CodeW-1:0] key_code
);
  import fwkd_pkg::*;

  logic [PinW-1:0] down;

  assign down = ~pin_levels;

  // lowest pin wins: up, down, left, right, enter
  always_comb begin
    if (down[0]) begin
      key_code = KEY_UP;
    end else if (down[1]) begin
      key_code = KEY_DOWN;
    end else if (down[2]) begin
      key_code = KEY_LEFT;
    end else if (down[3]) begin
      key_code = KEY_RIGHT;
    end else if (down[4]) begin
      key_code = KEY_ENTER;
    end else begin
      key_code = KEY_NONE;
    end
  end

endmodule
`default_nettype wire

@@ src/fwkd_fsm.sv @@
`default_nettype none
`include "five_way_key_debounce_fsm_unit_defines.svh"
module fwkd_fsm (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [fwkd_pkg::SkipW-1:0]   cfg_wr_data,
  input  wire fwkd_pkg::step_t              step,
  output fwkd_pkg::status_t                 status
);
  import fwkd_pkg::*;

  logic [SkipW-1:0] scan_skip_r;
  logic [SkipW-1:0] tick_count_r, tick_count_nxt;
  fsm_state_t       state_r, state_nxt;
  logic [CodeW-1:0] code_r, code_nxt;
  logic             press_r, press_nxt;
  logic             release_r, release_nxt;
  logic [CodeW-1:0] scan_code;
  logic             key_down;
  logic             do_scan;

  fwkd_prio_enc u_enc (
    .pin_levels (step.pin_levels),
    .key_code   (scan_code)
  );

  assign key_down = (scan_code != KEY_NONE);
  assign do_scan  = step.fire && !step.is_read && (tick_count_r >= scan_skip_r);

  always_comb begin
    tick_count_nxt = tick_count_r;
    state_nxt      = state_r;
    code_nxt       = code_r;
    press_nxt      = press_r;
    release_nxt    = release_r;
    if (step.fire && !step.is_read) begin
      if (do_scan) begin
        tick_count_nxt = '0;
        case (state_r)
          ST_PRESSED: begin
            if (key_down) begin
              state_nxt = ST_PRESS_OK;
              code_nxt  = scan_code;
              press_nxt = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_PRESS_OK: begin
            if (!key_down) state_nxt = ST_RELEASED;
          end
          ST_RELEASED: begin
            if (key_down) begin
              state_nxt = ST_PRESS_OK;
            end else begin
              state_nxt   = ST_RELEASE_OK;
              release_nxt = 1'b1;
            end
          end
          ST_RELEASE_OK: begin
            if (key_down) begin
              state_nxt = ST_PRESSED;
              code_nxt  = scan_code;
            end
          end
          default: begin
            state_nxt = key_down ? ST_PRESSED : ST_IDLE;
          end
        endcase
      end else begin
        tick_count_nxt = tick_count_r + 8'd1;
      end
    end else if (step.fire) begin
      case (state_r)
        ST_RELEASE_OK: begin
          state_nxt   = ST_IDLE;
          code_nxt    = KEY_NONE;
          press_nxt   = 1'b0;
          release_nxt = 1'b0;
        end
        ST_PRESS_OK, ST_RELEASED: begin
          press_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_skip_r  <= SCAN_SKIP_RESET;
      tick_count_r <= '0;
      state_r      <= ST_IDLE;
      code_r       <= KEY_NONE;
      press_r      <= 1'b0;
      release_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) scan_skip_r <= cfg_wr_data;
      tick_count_r <= tick_count_nxt;
      state_r      <= state_nxt;
      code_r       <= code_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
    end
  end

  // a read sees the values held before it
  assign status.key_code     = code_r;
  assign status.press_flag   = press_r;
  assign status.release_flag = release_r;

  `FWKD_ASSERT_NEXT(a_scan_restarts_count, do_scan, tick_count_r == '0,
    "tick counter not cleared after a scan")
  `FWKD_ASSERT_NOW(a_press_from_pressed, $rose(press_r), $past(state_r) == ST_PRESSED,
    "press flag set outside the pressed state")
  `FWKD_ASSERT_NOW(a_release_from_released, $rose(release_r),
    $past(state_r) == ST_RELEASED, "release flag set outside the released state")
  `FWKD_ASSERT_NEXT(a_read_clears_all,
    step.fire && step.is_read && state_r == ST_RELEASE_OK,
    state_r == ST_IDLE && code_r == KEY_NONE && !press_r && !release_r,
    "read in release confirmed did not clear status")

endmodule
`default_nettype wire

@@ src/five_way_key_debounce_fsm_unit.sv @@
// A read passes through the input register, then the result register, before its result is
// offered at the output. Throughput: one item per cycle, unless a read is held (below);
// ticks never produce a result transfer.
// A read waits in the input register only while the result register is full and stalled.
// Reset (rst_n low, synchronous): machine idle, tick count 0, code and flags 0,
// scan_skip back to 15, both pipeline registers empty.
`default_nettype none
module five_way_key_debounce_fsm_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration: scan_skip
  input  wire logic                         cfg_wr_en,
  input  wire logic [fwkd_pkg::SkipW-1:0]   cfg_wr_data,
  // item input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_action,
  input  wire logic [fwkd_pkg::PinW-1:0]    in_pin_levels,
  // result output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [fwkd_pkg::CodeW-1:0]   out_key_code,
  output logic                              out_press_flag,
  output logic                              out_release_flag
);
  import fwkd_pkg::*;

  // input register
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_action_r;
  logic [PinW-1:0] s1_pins_r;
  logic            s1_fire;
  logic            in_xfer;

  // result register
  logic            out_valid_r, out_valid_nxt;
  status_t         out_r;
  logic            out_load;

  step_t           step;
  status_t         status;

  // A tick always drains; a read drains when the result slot is free
  // or being emptied this cycle.
  assign s1_fire  = s1_valid_r &&
                    (s1_action_r == ACT_TICK || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = s1_fire && (s1_action_r == ACT_READ);

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r <= in_action;
      s1_pins_r   <= in_pin_levels;
    end
    if (out_load) out_r <= status;
  end

  assign step.fire       = s1_fire;
  assign step.is_read    = (s1_action_r == ACT_READ);
  assign step.pin_levels = s1_pins_r;

  // debounce state, tick divider and priority encode
  fwkd_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .status      (status)
  );

  assign out_valid        = out_valid_r;
  assign out_key_code     = out_r.key_code;
  assign out_press_flag   = out_r.press_flag;
  assign out_release_flag = out_r.release_flag;

endmodule
`default_nettype wire

@@ tb/five_way_key_debounce_fsm_unit_tb.sv @@
`timescale 1ns / 100ps

module five_way_key_debounce_fsm_unit_tb;
  import fwkd_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic             cfg_wr_en;
  logic [SkipW-1:0] cfg_wr_data;

  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [PinW-1:0]  in_pin_levels;

  logic             out_valid;
  logic             out_stall;
  logic [CodeW-1:0] out_key_code;
  logic             out_press_flag;
  logic             out_release_flag;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  five_way_key_debounce_fsm_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_code     (out_key_code),
    .out_press_flag   (out_press_flag),
    .out_release_flag (out_release_flag)
  );

  // ---------------------------------------------------------------------------
  // Debounce predictor: shadow copy of scan_skip, the tick counter, the
  // five-state machine and the latched key status.
  // ---------------------------------------------------------------------------
  logic [SkipW-1:0] skip_reg     = SCAN_SKIP_RESET;
  logic [SkipW-1:0] tick_cnt     = '0;
  fsm_state_t       key_state    = ST_IDLE;
  logic [CodeW-1:0] held_code    = KEY_NONE;
  logic             press_pend   = 1'b0;
  logic             release_pend = 1'b0;

  // Expected key status for every read transfer still in flight.
  status_t status_q[$];

  int unsigned fail_count = 0;

  // Advance the predictor by one accepted item. A read reports the status
  // held before the read; a tick reports nothing.
  function automatic void debounce_step(input logic act, input logic [PinW-1:0] pins,
                                        output status_t res, output bit has_res);
    logic [CodeW-1:0] key;
    // priority encode of active-low pins: up wins, enter loses
    if (!pins[0])      key = KEY_UP;
    else if (!pins[1]) key = KEY_DOWN;
    else if (!pins[2]) key = KEY_LEFT;
    else if (!pins[3]) key = KEY_RIGHT;
    else if (!pins[4]) key = KEY_ENTER;
    else               key = KEY_NONE;

    res     = '{held_code, press_pend, release_pend};
    has_res = (act == ACT_READ);

    if (act == ACT_TICK) begin
      // count at or above the skip (also after lowering it) -> scan now
      if (tick_cnt < skip_reg) begin
        tick_cnt = tick_cnt + 1'b1;
      end else begin
        tick_cnt = '0;
        case (key_state)
          ST_PRESSED: begin
            if (key != KEY_NONE) begin
              key_state  = ST_PRESS_OK;
              held_code  = key;
              press_pend = 1'b1;
            end else begin
              key_state = ST_IDLE;
            end
          end
          ST_PRESS_OK: begin
            if (key == KEY_NONE) key_state = ST_RELEASED;
          end
          ST_RELEASED: begin
            if (key != KEY_NONE) begin
              key_state = ST_PRESS_OK;
            end else begin
              key_state    = ST_RELEASE_OK;
              release_pend = 1'b1;
            end
          end
          ST_RELEASE_OK: begin
            // re-press: new code latched, release flag left alone
            if (key != KEY_NONE) begin
              key_state = ST_PRESSED;
              held_code = key;
            end
          end
          default: begin
            key_state = (key != KEY_NONE) ? ST_PRESSED : ST_IDLE;
          end
        endcase
      end
    end else begin
      case (key_state)
        ST_RELEASE_OK: begin
          held_code    = KEY_NONE;
          press_pend   = 1'b0;
          release_pend = 1'b0;
          key_state    = ST_IDLE;
        end
        ST_PRESS_OK, ST_RELEASED: press_pend = 1'b0;
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, i.e. the values that
  // the DUT sees at that edge. Directed rows may carry a hand-typed status that
  // travels with the item (row_typed / row_status) and overrides the predictor.
  // ---------------------------------------------------------------------------
  logic    row_typed;
  status_t row_status;

  always @(posedge clk) begin : mon
    status_t pred;
    status_t want;
    bit      has_res;
    if (rst_n) begin
      if (cfg_wr_en) skip_reg = cfg_wr_data;

      if (in_valid && !in_stall) begin
        debounce_step(in_action, in_pin_levels, pred, has_res);
        if (has_res) status_q.push_back(row_typed ? row_status : pred);
      end

      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: code %0d press %0b release %0b",
                     out_key_code, out_press_flag, out_release_flag);
        end else begin
          want = status_q.pop_front();
          if (out_key_code !== want.key_code || out_press_flag !== want.press_flag ||
              out_release_flag !== want.release_flag) begin
            fail_count++;
            if (fail_count <= 10)
              $display("status mismatch: want %0d/%0b/%0b, got %0d/%0b/%0b",
                       want.key_code, want.press_flag, want.release_flag,
                       out_key_code, out_press_flag, out_release_flag);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender / receiver pacing
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [SkipW-1:0] cur_skip = SCAN_SKIP_RESET;

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // One input transfer. in_valid is left high after acceptance so that a
  // back-to-back item never sees a low/high pair in the same step.
  task automatic put_item(input logic act, input logic [PinW-1:0] pins,
                          input logic typed, input status_t typed_status);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_pin_levels <= pins;
    row_typed     <= typed;
    row_status    <= typed_status;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending, let every read result come back, then give a tick that may
  // still sit in the input register time to reach the debounce machine.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_scan_skip(input logic [SkipW-1:0] val);
    wait_quiet();
    cfg_wr_data <= val;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_skip     = val;
  endtask

  // Random traffic: mostly held pin patterns long enough for one to three
  // scans at the current skip (so presses and releases get confirmed), reads
  // sprinkled in, plus some fully random noise items.
  task automatic run_burst(input int unsigned n);
    int unsigned sent;
    int unsigned hold_len;
    int unsigned k;
    logic [PinW-1:0] pat;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 15) begin
        put_item(1'($urandom_range(0, 1)), PinW'($urandom), 1'b0, '0);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0:       pat = '1;                                       // all released
          1:       pat = ~(PinW'(1) << $urandom_range(0, PinW-1)); // single key
          default: pat = PinW'($urandom);                          // any combo
        endcase
        hold_len = (int'(cur_skip) + 1) * $urandom_range(1, 3);
        for (k = 0; k < hold_len && sent < n; k++) begin
          if ($urandom_range(0, 99) < 20) begin
            put_item(ACT_READ, PinW'($urandom), 1'b0, '0);
            sent++;
          end
          put_item(ACT_TICK, pat, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Config rows are applied once the block is quiet. Typed
  // expectations only where obvious; the rest goes through the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             act;
    logic [PinW-1:0]  pins;
    logic             typed;
    status_t          want;
    logic [SkipW-1:0] skip;
  } script_row_t;

  localparam int unsigned NumRows = 28;

  localparam script_row_t SCRIPT [NumRows] = '{
    // right after reset: nothing latched
    '{ROW_ITEM, ACT_READ, 5'b11111, 1'b1, '{KEY_NONE,  1'b0, 1'b0}, 8'd0},
    // skip 15: these only count (count reaches 3)
    '{ROW_ITEM, ACT_TICK, 5'b11110, 1'b0, '0, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11110, 1'b0, '0, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11110, 1'b0, '0, 8'd0},
    // lower skip below the running count -> next tick scans at once
    '{ROW_CFG,  ACT_TICK, 5'b11111, 1'b0, '0, 8'd1},
    '{ROW_ITEM, ACT_TICK, 5'b00000, 1'b0, '0, 8'd0},   // all keys: up wins
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},   // skipped
    '{ROW_ITEM, ACT_TICK, 5'b00000, 1'b0, '0, 8'd0},   // press confirmed
    '{ROW_ITEM, ACT_READ, 5'b00000, 1'b1, '{KEY_UP,    1'b1, 1'b0}, 8'd0},
    '{ROW_CFG,  ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},   // scan every tick
    '{ROW_ITEM, ACT_READ, 5'b11111, 1'b1, '{KEY_UP,    1'b0, 1'b0}, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},   // released
    '{ROW_ITEM, ACT_TICK, 5'b01111, 1'b0, '0, 8'd0},   // bounce back to confirmed
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},   // release confirmed
    '{ROW_ITEM, ACT_READ, 5'b10101, 1'b1, '{KEY_UP,    1'b0, 1'b1}, 8'd0},
    '{ROW_ITEM, ACT_READ, 5'b01010, 1'b1, '{KEY_NONE,  1'b0, 1'b0}, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11101, 1'b0, '0, 8'd0},   // down: pressed
    '{ROW_ITEM, ACT_READ, 5'b11111, 1'b1, '{KEY_NONE,  1'b0, 1'b0}, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11011, 1'b0, '0, 8'd0},   // left latched
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0},   // release confirmed
    '{ROW_ITEM, ACT_TICK, 5'b10111, 1'b0, '0, 8'd0},   // re-press right, rel flag kept
    '{ROW_ITEM, ACT_READ, 5'b11111, 1'b0, '0, 8'd0},
    '{ROW_ITEM, ACT_TICK, 5'b01111, 1'b0, '0, 8'd0},   // enter confirmed
    '{ROW_ITEM, ACT_READ, 5'b00000, 1'b0, '0, 8'd0},
    '{ROW_CFG,  ACT_TICK, 5'b11111, 1'b0, '0, 8'd255}, // widest skip
    '{ROW_ITEM, ACT_TICK, 5'b11111, 1'b0, '0, 8'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned ph;
    int unsigned b;
    logic [SkipW-1:0] s;

    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_action     <= ACT_TICK;
    in_pin_levels <= '1;
    out_stall     <= 1'b0;
    row_typed     <= 1'b0;
    row_status    <= '0;
    send_idle_pct  = 19;
    recv_stall_pct = 53;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (SCRIPT[i].kind == ROW_CFG)
        set_scan_skip(SCRIPT[i].skip);
      else
        put_item(SCRIPT[i].act, SCRIPT[i].pins, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Three pacing phases: sender-light/receiver-heavy, swapped, then none.
    // Each phase walks a few skip settings; a lowered skip after a long one
    // also hits the count-above-skip case.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 19; recv_stall_pct = 53; end
        1:       begin send_idle_pct = 53; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (b = 0; b < 4; b++) begin
        case (b)
          0:       s = '0;
          1:       s = SkipW'($urandom_range(1, 3));
          2:       s = (ph == 0) ? '1 : SkipW'($urandom_range(4, 20));
          default: s = SkipW'($urandom_range(0, 2));
        endcase
        set_scan_skip(s);
        run_burst(60);
      end
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && status_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/fwkd_pkg.sv
src/fwkd_prio_enc.sv
src/fwkd_fsm.sv
src/five_way_key_debounce_fsm_unit.sv
tb/five_way_key_debounce_fsm_unit_tb.sv
